>>> rtl/fsss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_pkg
// Shared types and constants for the framed score stack sorter: field widths,
// mode codes, and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package fsss_pkg;

   localparam int MODE_W    = 3;
   localparam int VALUE_W   = 32;
   localparam int SCORE_W   = 32;
   localparam int INDEX_W   = 11;
   localparam int ENTRY_W   = VALUE_W + SCORE_W;

   localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKB = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOOKT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FREE  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SORT  = 3'd5;

   typedef enum logic [2:0] {
      RD_POP,
      RD_LOOKB,
      RD_LOOKT,
      RD_J,
      RD_IM1,
      RD_IM2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_PUSH,
      WR_SHIFT,
      WR_KEY
   } wr_sel_type;

   typedef enum logic [1:0] {
      TOP_HOLD,
      TOP_INC,
      TOP_DEC,
      TOP_FREE
   } top_op_type;

   typedef struct packed {
      logic       mem_we;
      wr_sel_type wr_sel;
      logic       rd_en;
      rd_sel_type rd_sel;
      top_op_type top_op;
      logic       flags_ld;
      logic       hit_val;
      logic       status_val;
      logic       sort_ld;
      logic       i_ld;
      logic       i_dec;
      logic       j_inc;
      logic       key_ld;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              full;
      logic              pop_ok;
      logic              lookb_ok;
      logic              lookt_ok;
      logic              sort_ok;
      logic              out_free;
      logic              prev_gt_key;
      logic              i_m1_is_base;
      logic              j_last;
   } sts_type;

endpackage
`default_nettype wire

>>> rtl/framed_score_stack_sorter_top.sv
// The response register loads in the finish state after acceptance, or after the last
// sort step for a sort, once the output is free; no new request is taken until then.
// Push, pop and look make at most one memory access and free none; then the
// response register loads. A sort goes key by key, paced by the single RAM read port.
// Reset is synchronous: clears pointer, null value and controller; the entry
// memory is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// framed_score_stack_sorter_top
// Bounded stack of value and score entries, split into frames by a base
// index, with push, pop, looks, free and a stable insertion sort by score.
// ----------------------------------------------------------------------------
module framed_score_stack_sorter_top
   import fsss_pkg::*;
#(
   parameter int STACK_DEPTH = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [MODE_W-1:0]         req_mode,
   input  wire logic [VALUE_W-1:0]        req_value_in,
   input  wire logic signed [SCORE_W-1:0] req_score_in,
   input  wire logic [INDEX_W-1:0]        req_frame_base,
   input  wire logic [INDEX_W-1:0]        req_offset,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [VALUE_W-1:0]             rsp_value_out,
   output logic signed [SCORE_W-1:0]      rsp_score_out,
   output logic                           rsp_hit,
   output logic [INDEX_W-1:0]             rsp_top_index,
   output logic                           rsp_status,
   input  wire logic                      csr_wr_en,
   input  wire logic [VALUE_W-1:0]        csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   fsss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fsss_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_mode       (req_mode),
      .req_value_in   (req_value_in),
      .req_score_in   (req_score_in),
      .req_frame_base (req_frame_base),
      .req_offset     (req_offset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_out  (rsp_value_out),
      .rsp_score_out  (rsp_score_out),
      .rsp_hit        (rsp_hit),
      .rsp_top_index  (rsp_top_index),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire

>>> rtl/fsss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_ram
// Generic single write port, single read port RAM with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module fsss_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/fsss_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_datapath
// Stack pointer, entry memory, sort indexes and key, null value register and
// the response register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module fsss_datapath
   import fsss_pkg::*;
#(
   parameter int STACK_DEPTH = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output sts_type                        sts,
   input  wire logic [MODE_W-1:0]         req_mode,
   input  wire logic [VALUE_W-1:0]        req_value_in,
   input  wire logic signed [SCORE_W-1:0] req_score_in,
   input  wire logic [INDEX_W-1:0]        req_frame_base,
   input  wire logic [INDEX_W-1:0]        req_offset,
   input  wire logic                      csr_wr_en,
   input  wire logic [VALUE_W-1:0]        csr_wr_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [VALUE_W-1:0]             rsp_value_out,
   output logic signed [SCORE_W-1:0]      rsp_score_out,
   output logic                           rsp_hit,
   output logic [INDEX_W-1:0]             rsp_top_index,
   output logic                           rsp_status
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W  = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;
   localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(STACK_DEPTH);

   logic [PTR_W-1:0]   top_ff, top_in;
   logic [VALUE_W-1:0] null_ff;
   logic [INDEX_W-1:0] base_ff;
   logic [ADDR_W-1:0]  i_ff, i_in;
   logic [ADDR_W-1:0]  j_ff, j_in;
   logic [ENTRY_W-1:0] key_ff;
   logic               hit_ff, status_ff;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic               rsp_hit_ff;
   logic [INDEX_W-1:0] rsp_top_ff;
   logic               rsp_status_ff;

   logic [CMP_W-1:0]   top_x, base_x, off_x, sbase_x, i_x, j_x, free_x, rd_calc, wr_calc;
   logic [ENTRY_W-1:0] rd_data, wr_data;

   always_comb begin
      top_x   = CMP_W'(top_ff);
      base_x  = CMP_W'(req_frame_base);
      off_x   = CMP_W'(req_offset);
      sbase_x = CMP_W'(base_ff);
      i_x     = CMP_W'(i_ff);
      j_x     = CMP_W'(j_ff);
      free_x  = (base_x > DEPTH_X) ? DEPTH_X : base_x;
   end

   always_comb begin
      sts.mode         = req_mode;
      sts.full         = top_x >= DEPTH_X;
      sts.pop_ok       = base_x < top_x;
      sts.lookb_ok     = (base_x + off_x) < top_x;
      sts.lookt_ok     = (off_x != '0) && (off_x <= top_x) && ((top_x - off_x) >= base_x);
      sts.sort_ok      = (base_x + CMP_W'(1)) < top_x;
      sts.out_free     = !rsp_valid_ff || rsp_ready;
      sts.prev_gt_key  = $signed(rd_data[SCORE_W-1:0]) > $signed(key_ff[SCORE_W-1:0]);
      sts.i_m1_is_base = (i_x - CMP_W'(1)) == sbase_x;
      sts.j_last       = (j_x + CMP_W'(1)) == top_x;
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_POP:   rd_calc = top_x - CMP_W'(1);
         RD_LOOKB: rd_calc = base_x + off_x;
         RD_LOOKT: rd_calc = top_x - off_x;
         RD_J:     rd_calc = j_x;
         RD_IM1:   rd_calc = i_x - CMP_W'(1);
         RD_IM2:   rd_calc = i_x - CMP_W'(2);
         default:  rd_calc = j_x;
      endcase
      case (cmd.wr_sel)
         WR_PUSH: begin
            wr_calc = top_x;
            wr_data = {req_value_in, req_score_in};
         end
         WR_SHIFT: begin
            wr_calc = i_x;
            wr_data = rd_data;
         end
         default: begin
            wr_calc = i_x;
            wr_data = key_ff;
         end
      endcase
   end

   fsss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH),
      .AW    (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_we),
      .wr_addr (wr_calc[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_calc[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.top_op)
         TOP_INC:  top_in = PTR_W'(top_x + CMP_W'(1));
         TOP_DEC:  top_in = PTR_W'(top_x - CMP_W'(1));
         TOP_FREE: top_in = free_x[PTR_W-1:0];
         default:  top_in = top_ff;
      endcase
      if (cmd.sort_ld) begin
         j_in = ADDR_W'(base_x + CMP_W'(1));
      end else if (cmd.j_inc) begin
         j_in = ADDR_W'(j_x + CMP_W'(1));
      end else begin
         j_in = j_ff;
      end
      if (cmd.i_ld) begin
         i_in = j_ff;
      end else if (cmd.i_dec) begin
         i_in = ADDR_W'(i_x - CMP_W'(1));
      end else begin
         i_in = i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         null_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff <= top_in;
         if (csr_wr_en) begin
            null_ff <= csr_wr_data;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      if (cmd.sort_ld) begin
         base_ff <= req_frame_base;
      end
      if (cmd.key_ld) begin
         key_ff <= rd_data;
      end
      if (cmd.flags_ld) begin
         hit_ff    <= cmd.hit_val;
         status_ff <= cmd.status_val;
      end
      if (cmd.out_load) begin
         rsp_value_ff  <= hit_ff ? rd_data[ENTRY_W-1:SCORE_W] : null_ff;
         rsp_score_ff  <= hit_ff ? rd_data[SCORE_W-1:0] : '0;
         rsp_hit_ff    <= hit_ff;
         rsp_top_ff    <= top_x[INDEX_W-1:0];
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_score_out = $signed(rsp_score_ff);
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_top_index = rsp_top_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
`default_nettype wire

>>> rtl/fsss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_ctrl
// Controller: decodes the request on acceptance, sequences the insertion sort
// over the frame and hands the result to the response register.
// ----------------------------------------------------------------------------
module fsss_ctrl
   import fsss_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FINISH,
      ST_SORT_KEY,
      ST_SORT_KEYW,
      ST_SORT_CMP,
      ST_SORT_PLACE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd        = '0;
      cmd.wr_sel = WR_PUSH;
      cmd.rd_sel = RD_J;
      cmd.top_op = TOP_HOLD;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.flags_ld = 1'b1;
               state_in     = ST_FINISH;
               unique case (sts.mode)
                  MODE_PUSH: begin
                     cmd.status_val = sts.full;
                     if (!sts.full) begin
                        cmd.mem_we = 1'b1;
                        cmd.top_op = TOP_INC;
                     end
                  end
                  MODE_POP: begin
                     if (sts.pop_ok) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_POP;
                        cmd.top_op  = TOP_DEC;
                        cmd.hit_val = 1'b1;
                     end
                  end
                  MODE_LOOKB: begin
                     if (sts.lookb_ok) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_LOOKB;
                        cmd.hit_val = 1'b1;
                     end
                  end
                  MODE_LOOKT: begin
                     if (sts.lookt_ok) begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_LOOKT;
                        cmd.hit_val = 1'b1;
                     end
                  end
                  MODE_FREE: begin
                     cmd.top_op = TOP_FREE;
                  end
                  MODE_SORT: begin
                     cmd.sort_ld = 1'b1;
                     if (sts.sort_ok) begin
                        state_in = ST_SORT_KEY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SORT_KEY: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_J;
            cmd.i_ld   = 1'b1;
            state_in   = ST_SORT_KEYW;
         end
         ST_SORT_KEYW: begin
            cmd.key_ld = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IM1;
            state_in   = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            cmd.mem_we = 1'b1;
            if (sts.prev_gt_key) begin
               cmd.wr_sel = WR_SHIFT;
               cmd.i_dec  = 1'b1;
               if (sts.i_m1_is_base) begin
                  state_in = ST_SORT_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_IM2;
               end
            end else begin
               cmd.wr_sel = WR_KEY;
               cmd.j_inc  = 1'b1;
               state_in   = sts.j_last ? ST_FINISH : ST_SORT_KEY;
            end
         end
         ST_SORT_PLACE: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = WR_KEY;
            cmd.j_inc  = 1'b1;
            state_in   = sts.j_last ? ST_FINISH : ST_SORT_KEY;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

>>> dv/framed_score_stack_sorter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_score_stack_sorter_top_test
// Self-checking bench for the framed score stack sorter. A directed table of
// transactions covers the empty, full and frame edge cases. Random framed
// push, pop, look, free and sort traffic follows across several null values.
// A behavioural stack model predicts each response not given by a typed table row,
// and the bench compares every field in order. Both channels get random idle bursts.
// ----------------------------------------------------------------------------
module framed_score_stack_sorter_top_test;
   import fsss_pkg::*;

   localparam int STACK_DEPTH = 1024;
   localparam int QUIET_LIMIT = 20000;
   localparam int SORT_SPAN_MAX = 48;
   localparam int RANDOM_PER_PHASE = 292;
   localparam int PHASES = 6;
   localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

   typedef struct {
      logic [MODE_W-1:0]         mode;
      logic [VALUE_W-1:0]        value;
      logic signed [SCORE_W-1:0] score;
      logic [INDEX_W-1:0]        base;
      logic [INDEX_W-1:0]        offset;
   } stack_req_type;

   typedef struct {
      logic [VALUE_W-1:0]        value;
      logic signed [SCORE_W-1:0] score;
      logic                      hit;
      logic [INDEX_W-1:0]        top;
      logic                      status;
   } stack_rsp_type;

   typedef struct {
      stack_req_type req;
      bit            typed;
      stack_rsp_type want;
   } table_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode = '0;
   logic [VALUE_W-1:0]        req_value_in = '0;
   logic signed [SCORE_W-1:0] req_score_in = '0;
   logic [INDEX_W-1:0]        req_frame_base = '0;
   logic [INDEX_W-1:0]        req_offset = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   logic [VALUE_W-1:0]        rsp_value_out;
   logic signed [SCORE_W-1:0] rsp_score_out;
   logic                      rsp_hit;
   logic [INDEX_W-1:0]        rsp_top_index;
   logic                      rsp_status;
   logic                      csr_wr_en = 1'b0;
   logic [VALUE_W-1:0]        csr_wr_data = '0;

   // stack model
   logic [VALUE_W-1:0]        stk_value [STACK_DEPTH];
   logic signed [SCORE_W-1:0] stk_score [STACK_DEPTH];
   bit                        stk_written [STACK_DEPTH];
   int                        stk_top = 0;
   logic [VALUE_W-1:0]        null_word = '0;

   stack_rsp_type pending_rsp [$];
   table_row_type stim_table [$];
   stack_rsp_type rsp_head;
   int            error_count = 0;
   int            quiet_cycles = 0;
   int            rsp_hold = 0;
   int            frame_start = 0;
   bit            idle_on = 1'b1;

   always #10 clock = ~clock;

   framed_score_stack_sorter_top #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value_in  (req_value_in),
      .req_score_in  (req_score_in),
      .req_frame_base(req_frame_base),
      .req_offset    (req_offset),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_score_out (rsp_score_out),
      .rsp_hit       (rsp_hit),
      .rsp_top_index (rsp_top_index),
      .rsp_status    (rsp_status),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   function automatic stack_rsp_type compute_response(stack_req_type r);
      stack_rsp_type o;
      int base;
      int off;
      int idx;
      int i;
      int j;
      logic [VALUE_W-1:0] kv;
      logic signed [SCORE_W-1:0] ks;
      base = r.base;
      off = r.offset;
      o.value = null_word;
      o.score = '0;
      o.hit = 1'b0;
      o.status = 1'b0;
      case (r.mode)
         MODE_PUSH: begin
            if (stk_top >= STACK_DEPTH) begin
               o.status = 1'b1;
            end else begin
               stk_value[stk_top] = r.value;
               stk_score[stk_top] = r.score;
               stk_written[stk_top] = 1'b1;
               stk_top++;
            end
         end
         MODE_POP: begin
            if (base < stk_top) begin
               stk_top--;
               o.value = stk_value[stk_top];
               o.score = stk_score[stk_top];
               o.hit = 1'b1;
            end
         end
         MODE_LOOKB: begin
            idx = base + off;
            if (idx < stk_top) begin
               o.value = stk_value[idx];
               o.score = stk_score[idx];
               o.hit = 1'b1;
            end
         end
         MODE_LOOKT: begin
            if (off != 0 && off <= stk_top && stk_top - off >= base) begin
               idx = stk_top - off;
               o.value = stk_value[idx];
               o.score = stk_score[idx];
               o.hit = 1'b1;
            end
         end
         MODE_FREE: stk_top = (base > STACK_DEPTH) ? STACK_DEPTH : base;
         MODE_SORT: begin
            if (base + 1 < stk_top) begin
               for (j = base + 1; j < stk_top; j++) begin
                  kv = stk_value[j];
                  ks = stk_score[j];
                  i = j;
                  while (i > base && stk_score[i-1] > ks) begin
                     stk_value[i] = stk_value[i-1];
                     stk_score[i] = stk_score[i-1];
                     i--;
                  end
                  stk_value[i] = kv;
                  stk_score[i] = ks;
               end
            end
         end
         default: ;
      endcase
      o.top = stk_top[INDEX_W-1:0];
      return o;
   endfunction

   function automatic bit reads_unwritten(stack_req_type r);
      int base;
      int off;
      int k;
      base = r.base;
      off = r.offset;
      case (r.mode)
         MODE_POP: return base < stk_top && !stk_written[stk_top-1];
         MODE_LOOKB: return base + off < stk_top && !stk_written[base+off];
         MODE_LOOKT:
            return off != 0 && off <= stk_top && stk_top - off >= base
               && !stk_written[stk_top-off];
         MODE_SORT: begin
            if (base + 1 < stk_top)
               for (k = base; k < stk_top; k++)
                  if (!stk_written[k]) return 1'b1;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic signed [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 3))
         0: return SCORE_W'($urandom_range(0, 6)) - 32'sd3;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic add_row(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v,
                          logic signed [SCORE_W-1:0] s, int b, int o, bit typed,
                          logic [VALUE_W-1:0] wv, logic signed [SCORE_W-1:0] ws,
                          bit wh, int wt, bit wst);
      table_row_type row;
      row.req.mode = m;
      row.req.value = v;
      row.req.score = s;
      row.req.base = b[INDEX_W-1:0];
      row.req.offset = o[INDEX_W-1:0];
      row.typed = typed;
      row.want.value = wv;
      row.want.score = ws;
      row.want.hit = wh;
      row.want.top = wt[INDEX_W-1:0];
      row.want.status = wst;
      stim_table.push_back(row);
   endtask

   task automatic drive_req(stack_req_type r, bit typed, stack_rsp_type want);
      stack_rsp_type model_rsp;
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_value_in <= r.value;
      req_score_in <= r.score;
      req_frame_base <= r.base;
      req_offset <= r.offset;
      do @(posedge clock); while (!req_ready);
      model_rsp = compute_response(r);
      pending_rsp.push_back(typed ? want : model_rsp);
   endtask

   task automatic gen_random_req(output stack_req_type r);
      int pick;
      int base;
      int span;
      int k;
      r.value = $urandom;
      r.score = pick_score();
      r.offset = '0;
      base = ($urandom_range(0, 99) < 88) ? frame_start : $urandom_range(0, STACK_DEPTH);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         r.mode = $urandom_range(0, 1) ? MODE_RSVD6 : MODE_RSVD7;
         r.offset = INDEX_W'($urandom_range(0, STACK_DEPTH));
      end else if (pick < 7) begin
         frame_start = stk_top;
         base = stk_top;
         r.mode = MODE_PUSH;
      end else if (pick < (stk_top < 80 ? 42 : 15)) begin
         r.mode = MODE_PUSH;
      end else if (pick < 55) begin
         r.mode = MODE_POP;
      end else if (pick < 79) begin
         r.mode = (pick < 67) ? MODE_LOOKB : MODE_LOOKT;
         span = stk_top - base;
         if (span < 0) span = 0;
         span = (span + 1 > STACK_DEPTH) ? STACK_DEPTH : span + 1;
         r.offset = ($urandom_range(0, 9) < 8) ? INDEX_W'($urandom_range(0, span))
                                              : INDEX_W'($urandom_range(0, STACK_DEPTH));
      end else if (pick < 87) begin
         r.mode = (stk_top - base > SORT_SPAN_MAX) ? MODE_LOOKB : MODE_SORT;
      end else if (pick < 98) begin
         r.mode = MODE_FREE;
         if (base == frame_start) frame_start = $urandom_range(0, frame_start);
      end else begin
         r.mode = MODE_FREE;
         base = $urandom_range(0, 1) ? STACK_DEPTH : $urandom_range(0, STACK_DEPTH);
      end
      r.base = base[INDEX_W-1:0];
      if (reads_unwritten(r)) begin
         // drop back to the longest fully written prefix
         k = 0;
         while (k < stk_top && stk_written[k]) k++;
         r.mode = MODE_FREE;
         r.base = k[INDEX_W-1:0];
         if (frame_start > k) frame_start = k;
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with none pending", rsp_value_out, '0);
         end else begin
            rsp_head = pending_rsp.pop_front();
            if (rsp_value_out !== rsp_head.value)
               report_mismatch("value_out", rsp_value_out, rsp_head.value);
            if (rsp_score_out !== rsp_head.score)
               report_mismatch("score_out", rsp_score_out, rsp_head.score);
            if (rsp_hit !== rsp_head.hit)
               report_mismatch("hit", 32'(rsp_hit), 32'(rsp_head.hit));
            if (rsp_top_index !== rsp_head.top)
               report_mismatch("top_index", 32'(rsp_top_index), 32'(rsp_head.top));
            if (rsp_status !== rsp_head.status)
               report_mismatch("status", 32'(rsp_status), 32'(rsp_head.status));
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         if (rsp_hold == 0) rsp_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("framed_score_stack_sorter_top_test: errors");
            $finish;
         end
      end
   end

   initial begin
      logic [VALUE_W-1:0] null_plan [PHASES];
      stack_req_type rnd_req;
      stack_rsp_type no_rsp;
      int p;
      int done;
      int n;

      no_rsp = '{default: '0};
      null_plan[0] = $urandom;
      null_plan[1] = 32'hFFFF_FFFF;
      null_plan[2] = 32'h0000_0000;
      null_plan[3] = $urandom;
      null_plan[4] = 32'h8000_0000;
      null_plan[5] = $urandom;

      //      mode        value          score          base  off  typed  value  score  hit top st
      add_row(MODE_POP,   32'h0,         32'sd0,        0,    0,    1,  32'h0, 0,     0,  0,   0);
      add_row(MODE_LOOKB, 32'h0,         32'sd0,        0,    0,    1,  32'h0, 0,     0,  0,   0);
      add_row(MODE_LOOKT, 32'h0,         32'sd0,        0,    0,    1,  32'h0, 0,     0,  0,   0);
      add_row(MODE_PUSH,  32'hFFFF_FFFF, 32'sh7FFF_FFFF, 0,   0,    1,  32'h0, 0,     0,  1,   0);
      add_row(MODE_PUSH,  32'h0,         32'sh8000_0000, 0,   0,    1,  32'h0, 0,     0,  2,   0);
      add_row(MODE_PUSH,  32'h1234_5678, -32'sd5,       0,    0,    1,  32'h0, 0,     0,  3,   0);
      add_row(MODE_PUSH,  32'hA5A5_A5A5, 32'sd0,        0,    0,    1,  32'h0, 0,     0,  4,   0);
      add_row(MODE_PUSH,  32'h5A5A_5A5A, -32'sd5,       0,    0,    1,  32'h0, 0,     0,  5,   0);
      add_row(MODE_LOOKB, 32'h0, 32'sd0, 0, 0, 1, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1, 5, 0);
      add_row(MODE_LOOKT, 32'h0,         32'sd0,        0,    1,    0,  32'h0, 0,     0,  0,   0);
      // zero offset from the top is a miss
      add_row(MODE_LOOKT, 32'h0,         32'sd0,        0,    0,    1,  32'h0, 0,     0,  5,   0);
      add_row(MODE_LOOKT, 32'h0,         32'sd0,        0, 1024,    1,  32'h0, 0,     0,  5,   0);
      add_row(MODE_LOOKB, 32'h0,         32'sd0,        0, 1024,    1,  32'h0, 0,     0,  5,   0);
      add_row(MODE_LOOKT, 32'h0,         32'sd0,        3,    3,    0,  32'h0, 0,     0,  0,   0);
      add_row(MODE_LOOKB, 32'h0,         32'sd0,        1,    4,    0,  32'h0, 0,     0,  0,   0);
      add_row(MODE_SORT,  32'h0,         32'sd0,        5,    0,    0,  32'h0, 0,     0,  0,   0);
      add_row(MODE_SORT,  32'h0,         32'sd0,        4,    0,    0,  32'h0, 0,     0,  0,   0);
      add_row(MODE_SORT,  32'h0,         32'sd0,        0,    0,    0,  32'h0, 0,     0,  0,   0);
      add_row(MODE_LOOKB, 32'h0,         32'sd0,        0,    1,    0,  32'h0, 0,     0,  0,   0);
      add_row(MODE_LOOKB, 32'h0,         32'sd0,        0,    2,    0,  32'h0, 0,     0,  0,   0);
      add_row(MODE_POP,   32'h0,         32'sd0,        0,    0,    0,  32'h0, 0,     0,  0,   0);
      add_row(MODE_POP,   32'h0,         32'sd0,        4,    0,    0,  32'h0, 0,     0,  0,   0);
      add_row(MODE_FREE,  32'h0,         32'sd0,        2,    0,    0,  32'h0, 0,     0,  0,   0);
      // free past the written entries, then push into a full stack
      add_row(MODE_FREE,  32'h0,         32'sd0,     1024,    0,    1,  32'h0, 0,     0, 1024, 0);
      add_row(MODE_PUSH,  32'hDEAD_BEEF, 32'sd1,        0,    0,    1,  32'h0, 0,     0, 1024, 1);
      add_row(MODE_RSVD6, 32'h0,         32'sd0,        0,    0,    1,  32'h0, 0,     0, 1024, 0);
      add_row(MODE_RSVD7, 32'hFFFF_FFFF, -32'sd1,    1024, 1024,    1,  32'h0, 0,     0, 1024, 0);
      add_row(MODE_FREE,  32'h0,         32'sd0,        0,    0,    1,  32'h0, 0,     0,  0,   0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i])
         drive_req(stim_table[i].req, stim_table[i].typed, stim_table[i].want);

      for (p = 0; p < PHASES; p++) begin
         drain_responses();
         csr_wr_en <= 1'b1;
         csr_wr_data <= null_plan[p];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         null_word = null_plan[p];
         done = 0;
         n = 0;
         while (done < RANDOM_PER_PHASE) begin
            if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (p == PHASES - 1 && done >= RANDOM_PER_PHASE - 200) idle_on = 1'b0;
            gen_random_req(rnd_req);
            drive_req(rnd_req, 1'b0, no_rsp);
            if (rnd_req.mode <= MODE_SORT) done++;
            n++;
         end
      end

      drain_responses();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("framed_score_stack_sorter_top_test: clean");
      else
         $display("framed_score_stack_sorter_top_test: errors");
      $finish;
   end

endmodule

>>> filelist.f
rtl/fsss_pkg.sv
rtl/fsss_ram.sv
rtl/fsss_datapath.sv
rtl/fsss_ctrl.sv
rtl/framed_score_stack_sorter_top.sv
dv/framed_score_stack_sorter_top_test.sv
